/* rtl/positional_list_engine_assert.svh */
// assertion macros for the positional list engine rtl
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// same-cycle implication on the block clock, off during reset
`define PLIST_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("plist assertion failed");

// next-cycle implication on the block clock, off during reset
`define PLIST_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("plist assertion failed");

`endif

/* rtl/plist_pkg.sv */
// types and codes shared by the positional list engine
`timescale 1ns / 1ps
`default_nettype none
package plist_pkg;

   // request codes
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_LOCATE = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [7:0]         position;
      logic signed [31:0] value;
   } plist_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         found_position;
      logic signed [31:0] removed_value;
      logic [7:0]         list_length;
   } plist_rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_RESULT
   } plist_state_type;

endpackage
`default_nettype wire

/* rtl/plist_mem.sv */
// entry store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module plist_mem #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  wire logic          clock,
   input  wire logic          mem_we,
   input  wire logic [AW-1:0] mem_waddr,
   input  wire logic [31:0]   mem_wdata,
   input  wire logic          mem_re,
   input  wire logic [AW-1:0] mem_raddr,
   output logic      [31:0]   rd_data
);

   logic [31:0] store_ff [DEPTH];
   logic [31:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= store_ff[mem_raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/plist_ctrl.sv */
// request sequencer: walks the entry store and builds the response
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_assert.svh"
module plist_ctrl #(
   parameter int CAPACITY = 128,
   parameter int AW       = 7
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire plist_pkg::plist_req_type req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output plist_pkg::plist_rsp_type     rsp_data,
   output logic                         mem_we,
   output logic [AW-1:0]                mem_waddr,
   output logic [31:0]                  mem_wdata,
   output logic                         mem_re,
   output logic [AW-1:0]                mem_raddr,
   input  wire logic [31:0]             rd_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = ((CW > 8) ? CW : 8) + 1;

   plist_pkg::plist_state_type state_ff, state_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [1:0]               kind_ff, kind_in;
   logic [AW-1:0]            pos_ff, pos_in;
   logic signed [31:0]       val_ff, val_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic [AW-1:0]            stop_ff, stop_in;
   logic [AW-1:0]            paddr_ff, paddr_in;
   logic                     pend_ff, pend_in;
   logic                     all_ff, all_in;
   logic                     hit_ff, hit_in;
   logic [CW-1:0]            found_ff, found_in;
   logic signed [31:0]       removed_ff, removed_in;
   logic [1:0]               status_ff, status_in;
   logic                     rsp_vld_ff, rsp_vld_in;
   plist_pkg::plist_rsp_type rsp_ff, rsp_in;

   logic [PW-1:0] ext_pos, ext_cnt, pos_m1, cnt_m1, cnt_p1;
   logic [PW-1:0] found_ext, cnt_new_ext;
   logic [CW-1:0] cnt_new;
   logic          match;

   // widened views of request position and count
   assign ext_pos   = PW'(req_data.position);
   assign ext_cnt   = PW'(cnt_ff);
   assign pos_m1    = ext_pos - PW'(1);
   assign cnt_m1    = ext_cnt - PW'(1);
   assign cnt_p1    = ext_cnt + PW'(1);
   assign found_ext = PW'(found_ff);

   // count after this transaction
   always_comb begin
      cnt_new = cnt_ff;
      if (status_ff == plist_pkg::STATUS_OK && kind_ff == plist_pkg::KIND_INSERT) begin
         cnt_new = cnt_ff + CW'(1);
      end else if (status_ff == plist_pkg::STATUS_OK &&
                   kind_ff == plist_pkg::KIND_DELETE) begin
         cnt_new = cnt_ff - CW'(1);
      end
   end
   assign cnt_new_ext = PW'(cnt_new);

   // first match while scanning for a value
   assign match = pend_ff && (kind_ff == plist_pkg::KIND_LOCATE) && !hit_ff &&
                  (rd_data == val_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= plist_pkg::S_IDLE;
         cnt_ff     <= '0;
         pend_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         pend_ff    <= pend_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      addr_ff    <= addr_in;
      stop_ff    <= stop_in;
      paddr_ff   <= paddr_in;
      all_ff     <= all_in;
      hit_ff     <= hit_in;
      found_ff   <= found_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   // next state, memory accesses and response
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      kind_in    = kind_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      addr_in    = addr_ff;
      stop_in    = stop_ff;
      paddr_in   = paddr_ff;
      pend_in    = 1'b0;
      all_in     = all_ff;
      hit_in     = hit_ff;
      found_in   = found_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = '0;
      mem_re     = 1'b0;
      mem_raddr  = addr_ff;

      case (state_ff)
         plist_pkg::S_IDLE: begin
            if (req_valid) begin
               kind_in    = req_data.req_type;
               val_in     = req_data.value;
               pos_in     = pos_m1[AW-1:0];
               status_in  = plist_pkg::STATUS_OK;
               found_in   = '0;
               removed_in = '0;
               hit_in     = 1'b0;
               all_in     = 1'b0;
               state_in   = plist_pkg::S_RESULT;
               case (req_data.req_type)
                  plist_pkg::KIND_INSERT: begin
                     if (ext_pos == '0 || ext_pos > cnt_p1) begin
                        status_in = plist_pkg::STATUS_RANGE;
                     end else if (ext_cnt == PW'(CAPACITY)) begin
                        status_in = plist_pkg::STATUS_FULL;
                     end else begin
                        // walk down from the tail, shifting each entry up
                        addr_in  = cnt_m1[AW-1:0];
                        stop_in  = pos_m1[AW-1:0];
                        all_in   = (ext_pos == cnt_p1);
                        state_in = plist_pkg::S_WALK;
                     end
                  end
                  plist_pkg::KIND_DELETE: begin
                     if (ext_pos == '0 || ext_pos > ext_cnt) begin
                        status_in = plist_pkg::STATUS_RANGE;
                     end else begin
                        // read the removed entry, then shift the rest down
                        addr_in  = pos_m1[AW-1:0];
                        stop_in  = cnt_m1[AW-1:0];
                        state_in = plist_pkg::S_WALK;
                     end
                  end
                  plist_pkg::KIND_LOCATE: begin
                     if (cnt_ff != '0) begin
                        addr_in  = '0;
                        stop_in  = cnt_m1[AW-1:0];
                        state_in = plist_pkg::S_WALK;
                     end
                  end
                  default: begin
                     status_in = plist_pkg::STATUS_RANGE;
                  end
               endcase
            end
         end

         plist_pkg::S_WALK: begin
            // consume read data from the previous cycle
            if (pend_ff) begin
               case (kind_ff)
                  plist_pkg::KIND_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = paddr_ff + AW'(1);
                     mem_wdata = rd_data;
                  end
                  plist_pkg::KIND_DELETE: begin
                     if (paddr_ff == pos_ff) begin
                        removed_in = rd_data;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = paddr_ff - AW'(1);
                        mem_wdata = rd_data;
                     end
                  end
                  default: begin
                     if (match) begin
                        hit_in   = 1'b1;
                        found_in = CW'(paddr_ff) + CW'(1);
                     end
                  end
               endcase
            end

            // issue the next read
            if (!all_ff && !hit_ff && !match) begin
               mem_re   = 1'b1;
               pend_in  = 1'b1;
               paddr_in = addr_ff;
               if (addr_ff == stop_ff) begin
                  all_in = 1'b1;
               end else if (kind_ff == plist_pkg::KIND_INSERT) begin
                  addr_in = addr_ff - AW'(1);
               end else begin
                  addr_in = addr_ff + AW'(1);
               end
            end
            if (match) begin
               all_in = 1'b1;
            end

            // all reads done and drained
            if (all_ff && !pend_ff) begin
               if (kind_ff == plist_pkg::KIND_INSERT) begin
                  mem_we    = 1'b1;
                  mem_waddr = pos_ff;
                  mem_wdata = val_ff;
               end
               state_in = plist_pkg::S_RESULT;
            end
         end

         plist_pkg::S_RESULT: begin
            if (!rsp_vld_ff || !rsp_stall) begin
               rsp_vld_in            = 1'b1;
               rsp_in.status         = status_ff;
               rsp_in.found_position = found_ext[7:0];
               rsp_in.removed_value  = removed_ff;
               rsp_in.list_length    = cnt_new_ext[7:0];
               cnt_in                = cnt_new;
               state_in              = plist_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = plist_pkg::S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != plist_pkg::S_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `PLIST_ASSERT_NOW(a_cnt_max, 1'b1, cnt_ff <= CW'(CAPACITY))
   `PLIST_ASSERT_NOW(a_idle_no_write, state_ff == plist_pkg::S_IDLE, !mem_we && !mem_re)
   `PLIST_ASSERT_NOW(a_pend_walk, pend_ff, state_ff == plist_pkg::S_WALK)
   `PLIST_ASSERT_NEXT(a_cnt_hold, state_ff != plist_pkg::S_RESULT, $stable(cnt_ff))

endmodule
`default_nettype wire

/* rtl/positional_list_engine.sv */
// top level of the positional list engine
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to CAPACITY signed 32-bit values held in one single-port-read,
// single-port-write memory. One transaction is handled at a time: req_stall stays
// high from acceptance until the response is queued in the output register, and a
// new request is taken while that response still waits on rsp_stall. Every read
// of the list goes through the memory read port, one entry per cycle. An insert
// walks from the tail down to position p (no walk when appending at count+1), a
// delete from p up to the tail, and a locate from the head to the first match or
// the tail; out-of-range, full, unused-code and empty-list locate requests go
// straight to the response without a walk. The list count is cleared by reset;
// the memory is not.
module positional_list_engine #(
   parameter int CAPACITY = 128
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire plist_pkg::plist_req_type req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output plist_pkg::plist_rsp_type      rsp_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [31:0]   rd_data;

   // sequencer
   plist_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .rd_data   (rd_data)
   );

   // entry store
   plist_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .rd_data   (rd_data)
   );

endmodule
`default_nettype wire
